[hw/rtl/cpu_bus_access_decoder_macros.svh]
// Assertion macros used by the bus access decoder datapath (cbad_dp).
// No dependencies; included by cbad_dp, which carries concurrent assertions.
`ifndef CPU_BUS_ACCESS_DECODER_MACROS_SVH
`define CPU_BUS_ACCESS_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CBAD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbad assertion failed");

// Next-cycle implication, disabled during reset.
`define CBAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbad assertion failed");

`endif

[hw/rtl/cbad_pkg.sv]
// Package for the bus access decoder: memory map constants, mode codes,
// word structs and controller/datapath command and status structs. No deps.
`default_nettype none

package cbad_pkg;

  localparam int ADDR_BITS = 16;
  localparam int MEM_DEPTH = 1 << ADDR_BITS;

  localparam logic [ADDR_BITS-1:0] RAM_MIRROR_MASK = 16'h07FF;
  localparam logic [ADDR_BITS-1:0] RAM_TOP         = 16'h1FFF;
  localparam logic [ADDR_BITS-1:0] DMA_PORT        = 16'h4014;
  localparam logic [ADDR_BITS-1:0] PAD_PORT        = 16'h4016;
  localparam logic [2:0]           PPU_PAGE_TAG    = 3'b001;

  localparam logic [7:0] PAD_IDLE_BITS = 8'h40;
  localparam logic [7:0] PAD_IDLE      = 8'hFF;
  localparam logic [7:0] PAD_LAST      = 8'd7;

  localparam logic [3:0] MODE_ACC  = 4'd0;
  localparam logic [3:0] MODE_IMM  = 4'd1;
  localparam logic [3:0] MODE_REL  = 4'd2;
  localparam logic [3:0] MODE_ZP   = 4'd3;
  localparam logic [3:0] MODE_ZPX  = 4'd4;
  localparam logic [3:0] MODE_ZPY  = 4'd5;
  localparam logic [3:0] MODE_ABS  = 4'd6;
  localparam logic [3:0] MODE_ABSX = 4'd7;
  localparam logic [3:0] MODE_ABSY = 4'd8;
  localparam logic [3:0] MODE_INDX = 4'd9;
  localparam logic [3:0] MODE_INDY = 4'd10;
  localparam logic [3:0] MODE_IND  = 4'd11;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic [1:0] PPU_NONE   = 2'd0;
  localparam logic [1:0] PPU_ACC_RD = 2'd1;
  localparam logic [1:0] PPU_ACC_WR = 2'd2;

  localparam logic [2:0] PPU_REG_STATUS  = 3'd2;
  localparam logic [2:0] PPU_REG_OAMDATA = 3'd4;
  localparam logic [2:0] PPU_REG_DATA    = 3'd7;

  typedef struct packed {
    logic       kind;
    logic [7:0] operand_low;
    logic [7:0] operand_high;
    logic [3:0] mode;
    logic [7:0] write_data;
    logic [7:0] index_x;
    logic [7:0] index_y;
    logic [7:0] accumulator_in;
    logic [7:0] pad_buttons;
  } in_word_t;

  typedef struct packed {
    logic [7:0]           read_data;
    logic                 read_from_ppu;
    logic [ADDR_BITS-1:0] effective_address;
    logic [1:0]           ppu_access;
    logic [2:0]           ppu_register;
    logic                 dma_start;
    logic [7:0]           dma_page;
    logic                 acc_write;
    logic [7:0]           acc_value;
  } out_word_t;

  typedef struct packed {
    logic load_in;
    logic ptr_lo_rd;
    logic ptr_hi_rd;
    logic load_ptr_lo;
    logic load_addr;
    logic exec;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic indirect;
    logic out_full;
  } ctl_sts_t;

endpackage

`default_nettype wire

[hw/rtl/cbad_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module cbad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hw/rtl/cbad_ctrl.sv]
// Sequencing state machine of the bus access decoder.
// Depends on cbad_pkg for the command and status structs.
`default_nettype none

module cbad_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire cbad_pkg::ctl_sts_t  sts,
  output cbad_pkg::ctl_cmd_t       cmd
);
  import cbad_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PLO  = 3'd1;
  localparam logic [2:0] S_PHI  = 3'd2;
  localparam logic [2:0] S_ADDR = 3'd3;
  localparam logic [2:0] S_EXEC = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load_in = 1'b1;
          state_nxt   = sts.indirect ? S_PLO : S_ADDR;
        end
      end
      S_PLO: begin
        cmd.ptr_lo_rd = 1'b1;
        state_nxt     = S_PHI;
      end
      S_PHI: begin
        cmd.ptr_hi_rd   = 1'b1;
        cmd.load_ptr_lo = 1'b1;
        state_nxt       = S_ADDR;
      end
      S_ADDR: begin
        cmd.load_addr = 1'b1;
        state_nxt     = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_full) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cbad_dp.sv]
// Datapath of the bus access decoder: operand capture, pointer fetch,
// address forming, map decode, pad/bus-hold state, memory and output word.
// Depends on cbad_pkg, cbad_ram and the assertion macro header.
`default_nettype none
`include "cpu_bus_access_decoder_macros.svh"

module cbad_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cbad_pkg::in_word_t  in_word,
  input  wire cbad_pkg::ctl_cmd_t  cmd,
  output cbad_pkg::ctl_sts_t       sts,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output cbad_pkg::out_word_t      out_word
);
  import cbad_pkg::*;

  in_word_t             iw_r;
  logic [7:0]           ptr_lo_r;
  logic [ADDR_BITS-1:0] eaddr_r, eaddr_nxt;
  logic [7:0]           bus_hold_r, bus_hold_nxt;
  logic [7:0]           pad_index_r, pad_index_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_word_r, res;

  logic [7:0]           zp_idx;
  logic [ADDR_BITS-1:0] base, ptr_word, plo_addr, phi_addr, maddr;
  logic                 is_ppu, is_dma, is_pad, mem_rd, mem_wr;
  logic [ADDR_BITS-1:0] ram_addr;
  logic                 ram_we, ram_re;
  logic [7:0]           ram_rdata;

  assign zp_idx   = iw_r.operand_low + iw_r.index_x;
  assign base     = {iw_r.operand_high, iw_r.operand_low};
  assign ptr_word = {ram_rdata, ptr_lo_r};

  always_comb begin
    unique case (iw_r.mode)
      MODE_INDX: begin
        plo_addr = {8'h00, zp_idx};
        phi_addr = {8'h00, zp_idx + 8'd1};
      end
      MODE_INDY: begin
        plo_addr = {8'h00, iw_r.operand_low};
        phi_addr = {8'h00, iw_r.operand_low + 8'd1};
      end
      default: begin
        plo_addr = base;
        phi_addr = {iw_r.operand_high, iw_r.operand_low + 8'd1};
      end
    endcase
  end

  always_comb begin
    unique case (iw_r.mode)
      MODE_ACC:  eaddr_nxt = (iw_r.kind == KIND_WRITE) ? '0 : {8'h00, iw_r.accumulator_in};
      MODE_IMM,
      MODE_REL,
      MODE_ZP:   eaddr_nxt = {8'h00, iw_r.operand_low};
      MODE_ZPX:  eaddr_nxt = {8'h00, zp_idx};
      MODE_ZPY:  eaddr_nxt = {8'h00, iw_r.operand_low + iw_r.index_y};
      MODE_ABS:  eaddr_nxt = base;
      MODE_ABSX: eaddr_nxt = base + {8'h00, iw_r.index_x};
      MODE_ABSY: eaddr_nxt = base + {8'h00, iw_r.index_y};
      MODE_INDX: eaddr_nxt = ptr_word;
      MODE_INDY: eaddr_nxt = ptr_word + {8'h00, iw_r.index_y};
      MODE_IND:  eaddr_nxt = ptr_word;
      default:   eaddr_nxt = '0;
    endcase
  end

  assign maddr  = (eaddr_r <= RAM_TOP) ? (eaddr_r & RAM_MIRROR_MASK) : eaddr_r;
  assign is_ppu = (maddr[ADDR_BITS-1:ADDR_BITS-3] == PPU_PAGE_TAG);
  assign is_dma = (maddr == DMA_PORT);
  assign is_pad = (maddr == PAD_PORT);

  always_comb begin
    res                   = '0;
    res.effective_address = eaddr_r;
    mem_rd                = 1'b0;
    mem_wr                = 1'b0;
    bus_hold_nxt          = bus_hold_r;
    pad_index_nxt         = pad_index_r;
    priority if (iw_r.mode > MODE_IND) begin
      res = '0;
    end else if (iw_r.kind == KIND_WRITE && iw_r.mode == MODE_ACC) begin
      res.acc_write = 1'b1;
      res.acc_value = iw_r.write_data;
    end else if (iw_r.kind == KIND_READ) begin
      priority if (iw_r.mode <= MODE_REL) begin
        res.read_data = eaddr_r[7:0];
      end else if (is_ppu) begin
        res.ppu_access   = PPU_ACC_RD;
        res.ppu_register = maddr[2:0];
        if (maddr[2:0] == PPU_REG_STATUS || maddr[2:0] == PPU_REG_OAMDATA ||
            maddr[2:0] == PPU_REG_DATA) begin
          res.read_from_ppu = 1'b1;
        end else begin
          res.read_data = bus_hold_r;
        end
      end else if (is_pad) begin
        res.read_data = PAD_IDLE_BITS;
        if (pad_index_r <= PAD_LAST) begin
          res.read_data[0] = iw_r.pad_buttons[pad_index_r[2:0]];
          pad_index_nxt    = (pad_index_r == PAD_LAST) ? PAD_IDLE : pad_index_r + 8'd1;
        end
      end else begin
        mem_rd        = 1'b1;
        res.read_data = ram_rdata;
      end
    end else begin
      priority if (is_ppu) begin
        bus_hold_nxt     = iw_r.write_data;
        res.ppu_access   = PPU_ACC_WR;
        res.ppu_register = maddr[2:0];
      end else if (is_dma) begin
        bus_hold_nxt  = iw_r.write_data;
        res.dma_start = 1'b1;
        res.dma_page  = iw_r.write_data;
      end else if (is_pad) begin
        pad_index_nxt = iw_r.write_data;
      end else begin
        mem_wr = 1'b1;
      end
    end
  end

  always_comb begin
    priority if (cmd.ptr_lo_rd) begin
      ram_addr = plo_addr;
    end else if (cmd.ptr_hi_rd) begin
      ram_addr = phi_addr;
    end else begin
      ram_addr = maddr;
    end
  end

  assign ram_re = cmd.ptr_lo_rd | cmd.ptr_hi_rd | (cmd.exec & mem_rd);
  assign ram_we = cmd.exec & mem_wr;

  cbad_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (iw_r.write_data),
    .rdata (ram_rdata)
  );

  always_comb begin
    priority if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      iw_r <= in_word;
    end
    if (cmd.load_ptr_lo) begin
      ptr_lo_r <= ram_rdata;
    end
    if (cmd.load_addr) begin
      eaddr_r <= eaddr_nxt;
    end
    if (cmd.finish) begin
      out_word_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      bus_hold_r  <= 8'h00;
      pad_index_r <= PAD_IDLE;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.finish) begin
        bus_hold_r  <= bus_hold_nxt;
        pad_index_r <= pad_index_nxt;
      end
    end
  end

  assign sts.indirect = (in_word.mode == MODE_INDX) || (in_word.mode == MODE_INDY) ||
                        (in_word.mode == MODE_IND);
  assign sts.out_full = out_valid_r & ~out_ready;
  assign out_valid    = out_valid_r;
  assign out_word     = out_word_r;

  `CBAD_ASSERT_NOW(a_no_rw_clash, clk, rst_n, ram_we, !ram_re)
  `CBAD_ASSERT_NOW(a_finish_slot_free, clk, rst_n, cmd.finish, !sts.out_full)
  `CBAD_ASSERT_NOW(a_exec_after_addr, clk, rst_n, cmd.exec, $past(cmd.load_addr))
  `CBAD_ASSERT_NOW(a_ptr_fetch_indirect, clk, rst_n, cmd.ptr_lo_rd,
    (iw_r.mode == MODE_INDX) || (iw_r.mode == MODE_INDY) || (iw_r.mode == MODE_IND))

endmodule

`default_nettype wire

[hw/rtl/cpu_bus_access_decoder.sv]
// Top level of the processor bus access decoder.
// Depends on cbad_pkg, cbad_ctrl, cbad_dp (which holds the cbad_ram memory).
//
// Usage:
//   Input channel in_valid/in_ready/in_word carries one bus access word:
//   kind, operands, mode, write data, X, Y, accumulator and pad buttons.
//   Output channel out_valid/out_ready/out_word returns one result word per
//   access: read data, effective address, PPU and DMA flags, accumulator write.
//   Sequence: a direct-mode access steps through the address, execute and done
//   states, and its result is registered as valid as it leaves done; indirect
//   modes (indexed-indirect, indirect-indexed, indirect) first fetch the two
//   pointer bytes, which share the single memory port with the data byte. One
//   access is in flight at a time: a new word is taken once the last finishes.
//   An output register holds a finished word; while the receiver stalls the
//   next access is still accepted and runs up to its final step, then waits.
//   Reset (rst_n low, synchronous) holds in_ready low and clears the
//   controller, the output valid, the bus hold byte (to 0) and the pad index
//   (to idle). Memory contents are not cleared and are undefined until written.
`default_nettype none

module cpu_bus_access_decoder (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire cbad_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output cbad_pkg::out_word_t      out_word
);
  import cbad_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  cbad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cbad_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

[tb/cpu_bus_access_decoder_test.sv]
// Self-checking testbench for cpu_bus_access_decoder: directed and random bus words
// are checked against a behavioral decoder model. Depends on cbad_pkg and the RTL.
`default_nettype none

module cpu_bus_access_decoder_test;
  import cbad_pkg::*;

  localparam int TIMEOUT_UNITS = 5_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS = 10;
  localparam logic [3:0] MODE_RESERVED = 4'd15;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  cpu_bus_access_decoder u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  // decoder model state
  logic [7:0]  mem_img [MEM_DEPTH];
  bit          mem_written [MEM_DEPTH];
  logic [15:0] stored_addrs[$];
  logic [7:0]  bus_hold = 8'h00;
  logic [7:0]  pad_shift_index = PAD_IDLE;
  bit          fetch_defined;

  out_word_t predicted_results[$];
  out_word_t head_result;
  int        accesses_sent = 0;
  int        mismatch_count = 0;
  int        send_idle_pct = 0;
  int        ready_stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= ready_stall_pct);

  function automatic logic [7:0] fetch_byte(input logic [15:0] addr);
    if (!mem_written[addr]) begin
      fetch_defined = 1'b0;
      return 8'h00;
    end
    return mem_img[addr];
  endfunction

  // Returns 0 when the word would read memory that was never written.
  // State is only updated when commit is set.
  function automatic bit decode_access(input in_word_t w, input bit commit,
                                       output out_word_t r);
    logic [15:0] ea;
    logic [15:0] a;
    logic [15:0] ptr;
    logic [7:0]  zp0;
    logic [7:0]  zp1;
    r = '0;
    ea = '0;
    fetch_defined = 1'b1;
    if (w.mode > MODE_IND) return 1'b1;
    if (w.kind == KIND_WRITE && w.mode == MODE_ACC) begin
      r.acc_write = 1'b1;
      r.acc_value = w.write_data;
      return 1'b1;
    end
    case (w.mode)
      MODE_ACC:  ea = {8'h00, w.accumulator_in};
      MODE_ZPX:  ea = {8'h00, w.operand_low + w.index_x};
      MODE_ZPY:  ea = {8'h00, w.operand_low + w.index_y};
      MODE_ABS:  ea = {w.operand_high, w.operand_low};
      MODE_ABSX: ea = {w.operand_high, w.operand_low} + {8'h00, w.index_x};
      MODE_ABSY: ea = {w.operand_high, w.operand_low} + {8'h00, w.index_y};
      MODE_INDX: begin
        zp0 = w.operand_low + w.index_x;
        zp1 = zp0 + 8'd1;
        ea = {fetch_byte({8'h00, zp1}), fetch_byte({8'h00, zp0})};
      end
      MODE_INDY: begin
        zp1 = w.operand_low + 8'd1;
        ptr = {fetch_byte({8'h00, zp1}), fetch_byte({8'h00, w.operand_low})};
        ea = ptr + {8'h00, w.index_y};
      end
      MODE_IND: begin
        // high pointer byte stays in the same page
        zp1 = w.operand_low + 8'd1;
        ea = {fetch_byte({w.operand_high, zp1}),
              fetch_byte({w.operand_high, w.operand_low})};
      end
      default: ea = {8'h00, w.operand_low};
    endcase
    r.effective_address = ea;
    a = (ea <= RAM_TOP) ? (ea & RAM_MIRROR_MASK) : ea;
    if (w.kind == KIND_READ) begin
      if (w.mode <= MODE_REL) begin
        r.read_data = ea[7:0];
      end else if (a[15:13] == PPU_PAGE_TAG) begin
        r.ppu_access = PPU_ACC_RD;
        r.ppu_register = a[2:0];
        if (a[2:0] == PPU_REG_STATUS || a[2:0] == PPU_REG_OAMDATA ||
            a[2:0] == PPU_REG_DATA)
          r.read_from_ppu = 1'b1;
        else
          r.read_data = bus_hold;
      end else if (a == PAD_PORT) begin
        r.read_data = PAD_IDLE_BITS;
        if (pad_shift_index <= PAD_LAST) begin
          r.read_data[0] = w.pad_buttons[pad_shift_index[2:0]];
          if (commit)
            pad_shift_index = (pad_shift_index == PAD_LAST) ? PAD_IDLE
                                                            : pad_shift_index + 8'd1;
        end
      end else begin
        r.read_data = fetch_byte(a);
      end
    end else begin
      if (a[15:13] == PPU_PAGE_TAG) begin
        r.ppu_access = PPU_ACC_WR;
        r.ppu_register = a[2:0];
        if (commit) bus_hold = w.write_data;
      end else if (a == DMA_PORT) begin
        r.dma_start = 1'b1;
        r.dma_page = w.write_data;
        if (commit) bus_hold = w.write_data;
      end else if (a == PAD_PORT) begin
        if (commit) pad_shift_index = w.write_data;
      end else if (commit) begin
        if (!mem_written[a]) stored_addrs.push_back(a);
        mem_written[a] = 1'b1;
        mem_img[a] = w.write_data;
      end
    end
    return fetch_defined;
  endfunction

  function automatic string show_result(input out_word_t r);
    return $sformatf("rd=%h from_ppu=%b ea=%h pa=%0d reg=%0d dma=%b page=%h aw=%b av=%h",
                     r.read_data, r.read_from_ppu, r.effective_address, r.ppu_access,
                     r.ppu_register, r.dma_start, r.dma_page, r.acc_write, r.acc_value);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (predicted_results.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("unexpected result word: %s", show_result(out_word));
        mismatch_count++;
      end else begin
        head_result = predicted_results.pop_front();
        if (out_word.read_data !== head_result.read_data ||
            out_word.read_from_ppu !== head_result.read_from_ppu ||
            out_word.effective_address !== head_result.effective_address ||
            out_word.ppu_access !== head_result.ppu_access ||
            out_word.ppu_register !== head_result.ppu_register ||
            out_word.dma_start !== head_result.dma_start ||
            out_word.dma_page !== head_result.dma_page ||
            out_word.acc_write !== head_result.acc_write ||
            out_word.acc_value !== head_result.acc_value) begin
          if (mismatch_count < MAX_REPORTS)
            $display("mismatch: expected %s, got %s", show_result(head_result),
                     show_result(out_word));
          mismatch_count++;
        end
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.kind = 1'($urandom_range(0, 1));
    w.operand_low = rand_byte();
    w.operand_high = rand_byte();
    w.mode = 4'($urandom_range(0, 15));
    w.write_data = rand_byte();
    w.index_x = rand_byte();
    w.index_y = rand_byte();
    w.accumulator_in = rand_byte();
    w.pad_buttons = rand_byte();
    return w;
  endfunction

  // Pick a mode and operands so that the word addresses t.
  function automatic in_word_t aim_at(input in_word_t w, input logic [15:0] t,
                                      input bit allow_operand_only);
    if (t[15:8] == 8'h00)
      w.mode = allow_operand_only ? 4'($urandom_range(1, 8)) : 4'($urandom_range(3, 8));
    else
      w.mode = 4'($urandom_range(6, 8));
    case (w.mode)
      MODE_ZPX:  w.operand_low = t[7:0] - w.index_x;
      MODE_ZPY:  w.operand_low = t[7:0] - w.index_y;
      MODE_ABS:  {w.operand_high, w.operand_low} = t;
      MODE_ABSX: {w.operand_high, w.operand_low} = t - {8'h00, w.index_x};
      MODE_ABSY: {w.operand_high, w.operand_low} = t - {8'h00, w.index_y};
      default:   w.operand_low = t[7:0];
    endcase
    return w;
  endfunction

  function automatic logic [15:0] pick_target();
    logic [15:0] t;
    logic [12:0] off;
    logic [1:0]  mirror;
    off = 13'($urandom);
    mirror = 2'($urandom);
    case ($urandom_range(0, 7))
      0: t = {PPU_PAGE_TAG, off};
      1: t = PAD_PORT;
      default: begin
        if (stored_addrs.size() == 0) begin
          t = PAD_PORT;
        end else begin
          t = stored_addrs[$urandom_range(0, stored_addrs.size() - 1)];
          if (t <= RAM_MIRROR_MASK) t[12:11] = mirror;
        end
      end
    endcase
    return t;
  endfunction

  task automatic issue_access(input in_word_t w);
    out_word_t r;
    in_word <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    void'(decode_access(w, 1'b1, r));
    predicted_results.push_back(r);
    if (w.mode <= MODE_IND) accesses_sent++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  task automatic issue_fields(input logic kind, input logic [3:0] mode,
                              input logic [15:0] operand, input logic [7:0] x,
                              input logic [7:0] y, input logic [7:0] wdata);
    in_word_t w;
    w = rand_word();
    w.kind = kind;
    w.mode = mode;
    {w.operand_high, w.operand_low} = operand;
    w.index_x = x;
    w.index_y = y;
    w.write_data = wdata;
    issue_access(w);
  endtask

  task automatic store_byte(input logic [15:0] addr, input logic [7:0] data);
    in_word_t w;
    w = rand_word();
    w.kind = KIND_WRITE;
    w.write_data = data;
    issue_access(aim_at(w, addr, 1'b1));
  endtask

  task automatic issue_store();
    logic [15:0] t;
    case ($urandom_range(0, 3))
      0: t = {8'h00, rand_byte()};
      1: t = 16'($urandom_range(0, RAM_TOP));
      default: t = 16'($urandom);
    endcase
    store_byte(t, rand_byte());
  endtask

  task automatic issue_or_store(input in_word_t w);
    out_word_t r;
    if (decode_access(w, 1'b0, r))
      issue_access(w);
    else
      issue_store();
  endtask

  task automatic issue_pointer_chain();
    in_word_t    w;
    logic [15:0] t;
    logic [15:0] q;
    logic [15:0] b;
    logic [7:0]  p;
    w = rand_word();
    w.kind = 1'($urandom_range(0, 1));
    t = (w.kind == KIND_READ) ? pick_target() : 16'($urandom);
    case ($urandom_range(0, 2))
      0: begin
        w.mode = MODE_INDX;
        p = w.operand_low + w.index_x;
        store_byte({8'h00, p}, t[7:0]);
        store_byte({8'h00, p + 8'd1}, t[15:8]);
      end
      1: begin
        w.mode = MODE_INDY;
        q = t - {8'h00, w.index_y};
        store_byte({8'h00, w.operand_low}, q[7:0]);
        store_byte({8'h00, w.operand_low + 8'd1}, q[15:8]);
      end
      default: begin
        w.mode = MODE_IND;
        b = $urandom_range(0, 1) ? 16'($urandom_range(0, RAM_MIRROR_MASK))
                                 : 16'($urandom_range(16'h4020, 16'hFFFF));
        {w.operand_high, w.operand_low} = b;
        store_byte(b, t[7:0]);
        store_byte({b[15:8], b[7:0] + 8'd1}, t[15:8]);
      end
    endcase
    issue_or_store(w);
  endtask

  task automatic issue_io_access();
    in_word_t    w;
    logic [15:0] t;
    logic [12:0] off;
    w = rand_word();
    off = 13'($urandom);
    t = {PPU_PAGE_TAG, off};
    if ($urandom_range(0, 3) == 0) begin
      w.kind = KIND_WRITE;
      t = DMA_PORT;
    end
    issue_access(aim_at(w, t, 1'b0));
  endtask

  task automatic issue_pad_sequence();
    in_word_t w;
    int       n;
    w = rand_word();
    w.kind = KIND_WRITE;
    case ($urandom_range(0, 4))
      0: w.write_data = PAD_IDLE;
      1: w.write_data = rand_byte();
      default: w.write_data = 8'($urandom_range(0, PAD_LAST));
    endcase
    issue_access(aim_at(w, PAD_PORT, 1'b0));
    n = $urandom_range(1, 9);
    repeat (n) begin
      w = rand_word();
      w.kind = KIND_READ;
      issue_access(aim_at(w, PAD_PORT, 1'b0));
    end
  endtask

  task automatic run_random_phase(input int sender_idle, input int receiver_stall,
                                  input int count);
    in_word_t w;
    int       stop_at;
    send_idle_pct = sender_idle;
    ready_stall_pct = receiver_stall;
    stop_at = accesses_sent + count;
    while (accesses_sent < stop_at) begin
      case ($urandom_range(0, 19))
        0: begin
          w = rand_word();
          w.mode = 4'($urandom_range(MODE_IND + 1, MODE_RESERVED));
          issue_access(w);
        end
        1, 2, 3, 4: issue_store();
        5, 6, 7, 8, 9: begin
          w = rand_word();
          w.kind = KIND_READ;
          issue_or_store(aim_at(w, pick_target(), 1'b0));
        end
        10, 11, 12: issue_pointer_chain();
        13, 14: issue_io_access();
        15, 16: issue_pad_sequence();
        default: issue_or_store(rand_word());
      endcase
    end
  endtask

  task automatic test_implied_modes();
    issue_fields(KIND_READ, MODE_ACC, 16'hFFFF, 8'h00, 8'hFF, 8'h00);
    issue_fields(KIND_WRITE, MODE_ACC, 16'h0000, 8'hFF, 8'h00, 8'hA5);
    issue_fields(KIND_READ, MODE_IMM, 16'h00FF, 8'h00, 8'h00, 8'hFF);
    issue_fields(KIND_WRITE, MODE_REL, 16'hFF10, 8'h00, 8'h00, 8'h3C);
  endtask

  task automatic test_direct_modes();
    issue_fields(KIND_WRITE, MODE_ZP, 16'h0020, 8'h00, 8'h00, 8'h11);
    issue_fields(KIND_READ, MODE_ZPX, 16'h00F0, 8'h30, 8'h00, 8'h00);
    issue_fields(KIND_WRITE, MODE_ABS, 16'h1FFF, 8'h00, 8'h00, 8'h77);
    issue_fields(KIND_READ, MODE_ABSY, 16'h0FF0, 8'h00, 8'h0F, 8'h00);
    issue_fields(KIND_READ, MODE_ABSX, 16'hFFFF, 8'h11, 8'h00, 8'h00);
  endtask

  task automatic test_indirect_modes();
    issue_fields(KIND_WRITE, MODE_ZP, 16'h00FF, 8'h00, 8'h00, 8'h10);
    issue_fields(KIND_WRITE, MODE_ZP, 16'h0000, 8'h00, 8'h00, 8'h00);
    issue_fields(KIND_READ, MODE_INDX, 16'h00FE, 8'h01, 8'h00, 8'h00);
    issue_fields(KIND_READ, MODE_INDY, 16'h00FF, 8'h00, 8'hEF, 8'h00);
    // pointer at the end of a page: high byte from the start of the same page
    issue_fields(KIND_WRITE, MODE_ABS, 16'h40FF, 8'h00, 8'h00, 8'h02);
    issue_fields(KIND_WRITE, MODE_ABS, 16'h4000, 8'h00, 8'h00, 8'h20);
    issue_fields(KIND_READ, MODE_IND, 16'h40FF, 8'hFF, 8'hFF, 8'h00);
  endtask

  task automatic test_ppu_and_dma();
    issue_fields(KIND_WRITE, MODE_ABS, 16'h2000, 8'h00, 8'h00, 8'hC3);
    issue_fields(KIND_READ, MODE_ABS, 16'h3FFD, 8'h00, 8'h00, 8'h00);
    issue_fields(KIND_READ, MODE_ABSX, 16'h2000, 8'h04, 8'h00, 8'h00);
    issue_fields(KIND_WRITE, MODE_ABS, DMA_PORT, 8'h00, 8'h00, 8'hFF);
  endtask

  task automatic test_pad_port();
    issue_fields(KIND_WRITE, MODE_ABS, PAD_PORT, 8'h00, 8'h00, 8'h06);
    repeat (3) issue_fields(KIND_READ, MODE_ABS, PAD_PORT, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_reserved_mode();
    issue_fields(KIND_WRITE, MODE_RESERVED, 16'h2000, 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, 90);
    run_random_phase(77, 0, 90);
    run_random_phase(0, 77, 90);
    run_random_phase(28, 28, 90);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_implied_modes();
    test_direct_modes();
    test_indirect_modes();
    test_ppu_and_dma();
    test_pad_port();
    test_reserved_mode();
    test_random_traffic();
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+hw/rtl
hw/rtl/cbad_pkg.sv
hw/rtl/cbad_ram.sv
hw/rtl/cbad_ctrl.sv
hw/rtl/cbad_dp.sv
hw/rtl/cpu_bus_access_decoder.sv
tb/cpu_bus_access_decoder_test.sv
